// File: rtl/trds_pkg.sv
`timescale 1ns / 1ps
// trds_pkg: shared types and codes for the task ready and delay scheduler
// no dependencies

package trds_pkg;

    localparam int KIND_W   = 2;
    localparam int PRIO_W   = 8;
    localparam int DELAY_W  = 15;
    localparam int TICK_W   = 16;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELAY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_READY = 2'd2;

    typedef struct packed {
        logic clear;
        logic en;
    } t_scan_ctl;

endpackage

// File: rtl/trds_ram.sv
`timescale 1ns / 1ps
// trds_ram: generic single write port, single read port ram with registered read
// no dependencies

module trds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/trds_head.sv
`timescale 1ns / 1ps
// trds_head: shared priority compare unit, tracks the most urgent ready task over a scan
// depends on trds_pkg

module trds_head #(
    parameter int IW = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  trds_pkg::t_scan_ctl       i_ctl,
    input  logic [IW-1:0]             i_idx,
    input  logic [trds_pkg::PRIO_W-1:0] i_prio,
    output logic                      o_found,
    output logic [IW-1:0]             o_best_idx
);
    import trds_pkg::*;

    logic              r_found;
    logic [IW-1:0]     r_best_idx;
    logic [PRIO_W-1:0] r_best_prio;
    logic              w_take;

    // strict compare keeps the lower id on a tie
    assign w_take = i_ctl.en && (!r_found || (i_prio < r_best_prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && w_take) begin
            r_best_idx  <= i_idx;
            r_best_prio <= i_prio;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;

endmodule

// File: rtl/task_ready_and_delay_scheduler_core.sv
`timescale 1ns / 1ps
// task_ready_and_delay_scheduler_core: task table sequencer with ready and delayed sets
// depends on trds_pkg, trds_ram, trds_head
// create and other kinds run one head scan from start to o_done, tick a wake scan then a head scan,
// delay with a nonzero delay and a ready task a head scan, a move of the head and a rescan; one table
// entry is read per cycle, in the head scan through the shared compare unit, busy stays high until
// the result strobe; start is taken again in the o_done cycle, not while a transaction is in progress
// reset: synchronous active low, clears ready and delayed sets, task count and tick counter
// the receiver cannot stall, o_done is high for exactly one cycle per transaction

module task_ready_and_delay_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [trds_pkg::KIND_W-1:0]    i_kind,
    input  logic [trds_pkg::PRIO_W-1:0]    i_task_priority,
    input  logic [trds_pkg::DELAY_W-1:0]   i_delay_ticks,
    output logic                           busy,
    output logic                           o_done,
    output logic                           o_ready_valid,
    output logic [trds_pkg::ID_W-1:0]      o_ready_head,
    output logic [trds_pkg::ID_W-1:0]      o_new_id,
    output logic [trds_pkg::STATUS_W-1:0]  o_status
);
    import trds_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] LAST = CW'(MAX_TASKS);

    typedef enum logic [1:0] {S_IDLE, S_WAKE, S_HEAD} t_state;

    t_state                r_state;
    logic                  r_dphase;
    logic [CW-1:0]         r_cnt;
    logic                  r_pv;
    logic [IW-1:0]         r_pidx;
    logic [MAX_TASKS-1:0]  r_ready;
    logic [MAX_TASKS-1:0]  r_delayed;
    logic [CW-1:0]         r_used;
    logic [TICK_W-1:0]     r_tick;
    logic [DELAY_W-1:0]    r_ticks;
    logic [ID_W-1:0]       r_new_id;
    logic [STATUS_W-1:0]   r_status;

    logic                  w_accept;
    logic                  w_scan_done;
    logic                  w_found;
    logic [IW-1:0]         w_best_idx;
    logic [PRIO_W-1:0]     w_prio_rd;
    logic [TICK_W-1:0]     w_wake_rd;
    logic [TICK_W-1:0]     w_diff;
    logic                  w_prio_we;
    logic                  w_wake_we;
    logic                  w_delay_move;
    t_scan_ctl             w_ctl;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_scan_done = (r_cnt == LAST) && !r_pv;
    assign w_diff      = r_tick - w_wake_rd;
    assign w_prio_we   = w_accept && (i_kind == KIND_CREATE) && (r_used < LAST);
    assign w_delay_move = (r_state == S_HEAD) && w_scan_done && r_dphase && w_found;
    assign w_wake_we   = w_delay_move;

    assign w_ctl.clear = w_accept || ((r_state == S_WAKE) && w_scan_done) || w_delay_move;
    assign w_ctl.en    = (r_state == S_HEAD) && r_pv && r_ready[r_pidx];

    trds_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (w_prio_we),
        .i_waddr (r_used[IW-1:0]),
        .i_wdata (i_task_priority),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_prio_rd)
    );

    trds_ram #(.WIDTH(TICK_W), .DEPTH(MAX_TASKS)) u_wake_ram (
        .i_clk   (i_clk),
        .i_we    (w_wake_we),
        .i_waddr (w_best_idx),
        .i_wdata (r_tick + TICK_W'(r_ticks)),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_wake_rd)
    );

    trds_head #(.IW(IW)) u_head (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (r_pidx),
        .i_prio     (w_prio_rd),
        .o_found    (w_found),
        .o_best_idx (w_best_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dphase  <= 1'b0;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_ready   <= '0;
            r_delayed <= '0;
            r_used    <= '0;
            r_tick    <= '0;
            o_done    <= 1'b0;
        end else begin
            o_done <= (r_state == S_HEAD) && w_scan_done && !w_delay_move;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt    <= '0;
                        r_pv     <= 1'b0;
                        r_dphase <= (i_kind == KIND_DELAY) && (i_delay_ticks != '0);
                        r_new_id <= w_prio_we ? ID_W'(r_used) : '0;
                        r_status <= ((i_kind == KIND_CREATE) && !w_prio_we) ? ST_FULL : ST_OK;
                        r_ticks  <= i_delay_ticks;
                        r_state  <= (i_kind == KIND_TICK) ? S_WAKE : S_HEAD;
                        case (i_kind)
                            KIND_CREATE: begin
                                if (r_used < LAST) begin
                                    r_ready[r_used[IW-1:0]] <= 1'b1;
                                    r_used   <= r_used + 1'b1;
                                end
                            end
                            KIND_TICK: begin
                                r_tick  <= r_tick + 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WAKE: begin
                    if (r_cnt != LAST) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pv   <= 1'b1;
                        r_pidx <= r_cnt[IW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    // wrap-safe due check
                    if (r_pv && r_delayed[r_pidx] && !w_diff[TICK_W-1]) begin
                        r_delayed[r_pidx] <= 1'b0;
                        r_ready[r_pidx]   <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_cnt   <= '0;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    if (r_cnt != LAST) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pv   <= 1'b1;
                        r_pidx <= r_cnt[IW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (w_scan_done) begin
                        if (w_delay_move) begin
                            // move head to the delayed set and rescan
                            r_ready[w_best_idx]   <= 1'b0;
                            r_delayed[w_best_idx] <= 1'b1;
                            r_dphase              <= 1'b0;
                            r_cnt                 <= '0;
                        end else begin
                            o_ready_valid <= w_found;
                            o_ready_head  <= w_found ? ID_W'(w_best_idx) : '0;
                            o_new_id      <= r_new_id;
                            o_status      <= r_dphase ? ST_NO_READY : r_status;
                            r_dphase      <= 1'b0;
                            r_state       <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_sets_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & r_delayed) == '0)
        else $error("task both ready and delayed");

    a_done_from_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_HEAD))
        else $error("result strobe without head scan");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("transaction accepted but block not busy");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= LAST)
        else $error("task count beyond table size");

    a_full_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_new_id == '0))
        else $error("full table reported a new id");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for task_ready_and_delay_scheduler_core, directed vectors then random
// depends on trds_pkg and task_ready_and_delay_scheduler_core; results checked against fixed values
// for the first directed vectors, else against a scheduler model kept in the bench

module tb;
    import trds_pkg::*;

    localparam int MAX_TASKS   = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN       = 2 * MAX_TASKS + 8;
    localparam int RANDOM_TXNS = 400;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PRIO_W-1:0]  prio;
        logic [DELAY_W-1:0] ticks;
    } sched_txn_t;

    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     head;
        logic [ID_W-1:0]     new_id;
        logic [STATUS_W-1:0] status;
    } sched_result_t;

    typedef struct packed {
        sched_txn_t    txn;
        logic          fixed;
        sched_result_t res;
    } sched_vector_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [KIND_W-1:0]   i_kind = '0;
    logic [PRIO_W-1:0]   i_task_priority = '0;
    logic [DELAY_W-1:0]  i_delay_ticks = '0;
    logic                busy;
    logic                o_done;
    logic                o_ready_valid;
    logic [ID_W-1:0]     o_ready_head;
    logic [ID_W-1:0]     o_new_id;
    logic [STATUS_W-1:0] o_status;

    // scheduler state as the bench sees it
    logic [PRIO_W-1:0]    prio_tbl [MAX_TASKS];
    logic [TICK_W-1:0]    wake_tbl [MAX_TASKS];
    logic [MAX_TASKS-1:0] ready_set = '0;
    logic [MAX_TASKS-1:0] delayed_set = '0;
    int                   task_count = 0;
    logic [TICK_W-1:0]    tick_cnt = '0;

    sched_result_t expected_q [$];
    sched_vector_t directed_vectors [$];
    int            mismatch_count = 0;
    int            stall_cycles = 0;

    task_ready_and_delay_scheduler_core #(
        .MAX_TASKS(MAX_TASKS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_kind          (i_kind),
        .i_task_priority (i_task_priority),
        .i_delay_ticks   (i_delay_ticks),
        .busy            (busy),
        .o_done          (o_done),
        .o_ready_valid   (o_ready_valid),
        .o_ready_head    (o_ready_head),
        .o_new_id        (o_new_id),
        .o_status        (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // most urgent ready task, lowest id on a tie
    function automatic void find_urgent(output logic found, output int id);
        found = 1'b0;
        id = 0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (ready_set[i] && (!found || prio_tbl[i] < prio_tbl[id])) begin
                id = i;
                found = 1'b1;
            end
        end
    endfunction

    function automatic sched_result_t schedule_step(sched_txn_t t);
        sched_result_t     r;
        logic              found;
        int                head;
        logic [TICK_W-1:0] lag;
        r = '0;
        case (t.kind)
            KIND_CREATE: begin
                if (task_count >= MAX_TASKS) begin
                    r.status = ST_FULL;
                end else begin
                    r.new_id = task_count[ID_W-1:0];
                    prio_tbl[task_count] = t.prio;
                    ready_set[task_count] = 1'b1;
                    task_count++;
                end
            end
            KIND_DELAY: begin
                if (t.ticks != '0) begin
                    find_urgent(found, head);
                    if (!found) begin
                        r.status = ST_NO_READY;
                    end else begin
                        wake_tbl[head] = tick_cnt + {1'b0, t.ticks};
                        ready_set[head] = 1'b0;
                        delayed_set[head] = 1'b1;
                    end
                end
            end
            KIND_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (delayed_set[i]) begin
                        // due once the wake time is not ahead, wrap safe
                        lag = tick_cnt - wake_tbl[i];
                        if (!lag[TICK_W-1]) begin
                            delayed_set[i] = 1'b0;
                            ready_set[i] = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        find_urgent(found, head);
        r.valid = found;
        r.head = found ? head[ID_W-1:0] : '0;
        return r;
    endfunction

    task automatic add_vector(input logic [KIND_W-1:0] kind, input int prio, input int ticks,
                              input logic fixed, input logic valid, input int head,
                              input int new_id, input logic [STATUS_W-1:0] status);
        sched_vector_t v;
        v.txn.kind = kind;
        v.txn.prio = prio[PRIO_W-1:0];
        v.txn.ticks = ticks[DELAY_W-1:0];
        v.fixed = fixed;
        v.res.valid = valid;
        v.res.head = head[ID_W-1:0];
        v.res.new_id = new_id[ID_W-1:0];
        v.res.status = status;
        directed_vectors.push_back(v);
    endtask

    // holds start until the transaction is taken, then books its result
    task automatic send_txn(input sched_txn_t t, input logic fixed, input sched_result_t fixed_res);
        sched_result_t predicted;
        start <= 1'b1;
        i_kind <= t.kind;
        i_task_priority <= t.prio;
        i_delay_ticks <= t.ticks;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = schedule_step(t);
        expected_q.push_back(fixed ? fixed_res : predicted);
    endtask

    function automatic int pick_gap(int n);
        int r;
        if ((n / 50) % 3 == 2) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(5, 60);
    endfunction

    function automatic sched_txn_t random_txn();
        sched_txn_t t;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 12) t.kind = KIND_CREATE;
        else if (r < 45) t.kind = KIND_DELAY;
        else if (r < 92) t.kind = KIND_TICK;
        else t.kind = KIND_NONE;
        t.prio = PRIO_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 10) t.ticks = '0;
        else if (r < 80) t.ticks = DELAY_W'($urandom_range(1, 6));
        else if (r < 97) t.ticks = DELAY_W'($urandom_range(7, 64));
        else t.ticks = DELAY_W'($urandom_range(0, 32767));
        return t;
    endfunction

    always @(posedge i_clk) begin : result_check
        sched_result_t want;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_ready_valid !== want.valid) begin
                    $error("ready_valid: expected %0d, got %0d", want.valid, o_ready_valid);
                    mismatch_count++;
                end
                if (o_ready_head !== want.head) begin
                    $error("ready_head: expected %0d, got %0d", want.head, o_ready_head);
                    mismatch_count++;
                end
                if (o_new_id !== want.new_id) begin
                    $error("new_id: expected %0d, got %0d", want.new_id, o_new_id);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[task_ready_and_delay_scheduler_core] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        sched_vector_t v;
        int            gap;
        add_vector(KIND_TICK,     0,     0, 1'b1, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_DELAY,    0,     5, 1'b1, 1'b0, 0, 0, ST_NO_READY);
        add_vector(KIND_DELAY,  255,     0, 1'b1, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_NONE,   255, 32767, 1'b1, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_CREATE, 255,     0, 1'b1, 1'b1, 0, 0, ST_OK);
        add_vector(KIND_CREATE,   0, 32767, 1'b1, 1'b1, 1, 1, ST_OK);
        add_vector(KIND_CREATE,   0,     0, 1'b1, 1'b1, 1, 2, ST_OK);
        add_vector(KIND_DELAY,  170, 32767, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_DELAY,   85,     1, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_TICK,     0,     0, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_DELAY,    0,     0, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_CREATE, 128, 21845, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_CREATE, 127, 10922, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_DELAY,    0,     3, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_DELAY,    0,     2, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_TICK,   255, 32767, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_CREATE,  85,     0, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_CREATE, 170,     0, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_NONE,     0,     0, 1'b0, 1'b0, 0, 0, ST_OK);
        add_vector(KIND_TICK,     0,     0, 1'b0, 1'b0, 0, 0, ST_OK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < directed_vectors.size() + RANDOM_TXNS; n++) begin
            if (n < directed_vectors.size()) begin
                v = directed_vectors[n];
            end else begin
                v.txn = random_txn();
                v.fixed = 1'b0;
                v.res = '0;
            end
            send_txn(v.txn, v.fixed, v.res);
            gap = pick_gap(n);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[task_ready_and_delay_scheduler_core] OK");
        end else begin
            $display("[task_ready_and_delay_scheduler_core] ERROR");
        end
        $finish;
    end

endmodule

// File: task_ready_and_delay_scheduler_core.f
rtl/trds_pkg.sv
rtl/trds_ram.sv
rtl/trds_head.sv
rtl/task_ready_and_delay_scheduler_core.sv
sim/tb.sv
